// ===== rtl/core/utf8e_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8e_pkg
// shared types and constants for the utf-16le to utf-8 stream encoder
// ----------------------------------------------------------------------------
package utf8e_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int CAP_W       = 16;

	typedef enum logic [1:0] {
		END_NULL    = 2'd0,
		END_FULL    = 2'd1,
		END_EXHAUST = 2'd2
	} end_reason_t;

	// one classified request from the front: up to three utf-8 bytes and
	// an optional terminator after them
	typedef struct packed {
		logic [15:0] unit;
		logic [1:0]  nbytes;
		logic        term;
		end_reason_t reason;
	} op_t;

endpackage

// ===== rtl/core/utf8e_front.sv =====
// ----------------------------------------------------------------------------
// utf8e_front
// pairs input bytes into code units, tracks positions and capacity, and
// classifies each code unit or end into an encode request for the back end
// ----------------------------------------------------------------------------
module utf8e_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [7:0]                        in_byte,
	input  logic                              string_start,
	input  logic                              cfg_we,
	input  logic [utf8e_pkg::CAP_W-1:0]       cfg_wdata,
	input  logic                              q_full,
	output logic                              op_push,
	output utf8e_pkg::op_t                    op
);
	import utf8e_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic [7:0]       held_q, held_nx;
	logic             phase_q, phase_nx;
	logic [15:0]      in_pos_q, in_pos_nx;
	logic [15:0]      out_pos_q, out_pos_nx;
	logic             stopped_q, stopped_nx;

	logic             accept;
	logic             eff_stop, eff_phase;
	logic [15:0]      eff_in, eff_out;
	logic [15:0]      unit;
	logic [1:0]       n;
	logic [16:0]      out_sum;
	logic [15:0]      in_step;
	logic             in_full, out_full, next_in_full;

	assign full   = q_full;
	assign accept = push && !q_full;

	// a new string clears the positions before this byte is looked at
	assign eff_stop  = string_start ? 1'b0 : stopped_q;
	assign eff_phase = string_start ? 1'b0 : phase_q;
	assign eff_in    = string_start ? 16'd0 : in_pos_q;
	assign eff_out   = string_start ? 16'd0 : out_pos_q;

	assign unit = {in_byte, held_q};
	always_comb begin
		if (unit[15:7] == 9'd0) begin
			n = 2'd1;
		end else if (unit[15:11] == 5'd0) begin
			n = 2'd2;
		end else begin
			n = 2'd3;
		end
	end

	assign in_full      = ({1'b0, eff_in} + 17'd2) > {1'b0, capacity_q};
	assign out_sum      = {1'b0, eff_out} + {15'd0, n};
	assign out_full     = out_sum >= {1'b0, capacity_q};
	assign in_step      = eff_in + 16'd2;
	assign next_in_full = ({1'b0, in_step} + 17'd2) > {1'b0, capacity_q};

	always_comb begin
		op_push    = 1'b0;
		op         = '0;
		op.reason  = END_NULL;
		held_nx    = held_q;
		phase_nx   = phase_q;
		in_pos_nx  = in_pos_q;
		out_pos_nx = out_pos_q;
		stopped_nx = stopped_q;
		if (accept) begin
			phase_nx   = eff_phase;
			in_pos_nx  = eff_in;
			out_pos_nx = eff_out;
			stopped_nx = eff_stop;
			if (!eff_stop) begin
				if (!eff_phase) begin
					if (in_full) begin
						op_push    = 1'b1;
						op.term    = 1'b1;
						op.reason  = END_EXHAUST;
						stopped_nx = 1'b1;
					end else begin
						held_nx  = in_byte;
						phase_nx = 1'b1;
					end
				end else begin
					phase_nx = 1'b0;
					if (unit == 16'd0) begin
						op_push    = 1'b1;
						op.term    = 1'b1;
						op.reason  = END_NULL;
						stopped_nx = 1'b1;
					end else if (out_full) begin
						op_push    = 1'b1;
						op.term    = 1'b1;
						op.reason  = END_FULL;
						stopped_nx = 1'b1;
					end else begin
						op_push    = 1'b1;
						op.unit    = unit;
						op.nbytes  = n;
						out_pos_nx = out_sum[15:0];
						in_pos_nx  = in_step;
						if (next_in_full) begin
							op.term    = 1'b1;
							op.reason  = END_EXHAUST;
							stopped_nx = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= '0;
			held_q     <= '0;
			phase_q    <= 1'b0;
			in_pos_q   <= '0;
			out_pos_q  <= '0;
			stopped_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			held_q    <= held_nx;
			phase_q   <= phase_nx;
			in_pos_q  <= in_pos_nx;
			out_pos_q <= out_pos_nx;
			stopped_q <= stopped_nx;
		end
	end

	a_push_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		op_push |-> (op.term || op.nbytes != 2'd0))
		else $error("front pushed a request with no results");

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stopped_q && !string_start) |-> !op_push)
		else $error("front produced a request after the terminator");

endmodule

// ===== rtl/core/utf8e_queue.sv =====
// ----------------------------------------------------------------------------
// utf8e_queue
// short request queue between the front and the back end
// ----------------------------------------------------------------------------
module utf8e_queue #(
	parameter int DEPTH = utf8e_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  utf8e_pkg::op_t wdata,
	input  logic           pop,
	output utf8e_pkg::op_t rdata,
	output logic           full,
	output logic           empty
);
	import utf8e_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("request pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("request popped from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ===== rtl/core/utf8e_back.sv =====
// ----------------------------------------------------------------------------
// utf8e_back
// walks the head request one result per cycle into the free output register
// ----------------------------------------------------------------------------
module utf8e_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  utf8e_pkg::op_t head,
	output logic           head_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           is_last,
	output logic [1:0]     end_reason
);
	import utf8e_pkg::*;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        is_last_q;
	end_reason_t end_reason_q;
	logic [1:0]  step_q;

	logic        load;
	logic [2:0]  count;
	logic        last_step;
	logic [7:0]  byte_nx;
	logic        is_byte;

	assign count     = {1'b0, head.nbytes} + {2'b0, head.term};
	assign last_step = {1'b0, step_q} == count - 3'd1;
	assign load      = head_valid && (!out_valid_q || pop);
	assign head_pop  = load && last_step;
	assign is_byte   = step_q < head.nbytes;

	always_comb begin
		unique case ({head.nbytes, step_q})
			{2'd1, 2'd0}: byte_nx = head.unit[7:0];
			{2'd2, 2'd0}: byte_nx = {3'b110, head.unit[10:6]};
			{2'd2, 2'd1}: byte_nx = {2'b10, head.unit[5:0]};
			{2'd3, 2'd0}: byte_nx = {4'b1110, head.unit[15:12]};
			{2'd3, 2'd1}: byte_nx = {2'b10, head.unit[11:6]};
			{2'd3, 2'd2}: byte_nx = {2'b10, head.unit[5:0]};
			default:      byte_nx = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q      <= last_step ? 2'd0 : step_q + 2'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= is_byte ? byte_nx : 8'd0;
			is_last_q    <= !is_byte;
			end_reason_q <= is_byte ? END_NULL : head.reason;
		end
	end

	assign empty      = !out_valid_q;
	assign out_byte   = out_byte_q;
	assign is_last    = is_last_q;
	assign end_reason = end_reason_q;

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_last_q) |-> (out_byte_q == 8'd0))
		else $error("terminator carries a nonzero byte");

	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (step_q == 2'd0))
		else $error("step counter moved with no request");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> ({1'b0, step_q} < count))
		else $error("step counter beyond request length");

endmodule

// ===== rtl/core/utf8e_top.sv =====
// ----------------------------------------------------------------------------
// utf16le_to_utf8_stream_encoder_top
// utf-16le byte stream in, utf-8 bytes with a terminator out
// ----------------------------------------------------------------------------
// Input is a queue-style port: a byte with string_start is taken on an edge
// with push high and full low. Results come out queue-style: out_byte,
// is_last and end_reason are valid while empty is low and are taken on an
// edge with pop high. The user must write the capacity register with
// cfg_we/cfg_wdata while the block is idle; the block does not enforce this.
// The front takes one byte per cycle while full is low, updates the pairing
// and position counters at once and places any encode request in a small
// queue. The back end drains the head request at one result per cycle, while
// the output register is empty or popped, through that register. The first
// result thus passes through the queue and then the output register before
// it is on the output ports. A high byte can cause up to four results, so in
// steady state the output port limits the rate; the queue of QUEUE_DEPTH
// requests absorbs bursts. full rises when that queue is full.
// When the receiver stalls, the output register holds, the queue fills and
// full then holds off the sender. Reset clears the queue, the counters and
// the capacity (to zero); a string is in progress from reset on.
// ----------------------------------------------------------------------------
module utf16le_to_utf8_stream_encoder_top #(
	parameter int QUEUE_DEPTH = utf8e_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  in_byte,
	input  logic                        string_start,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  out_byte,
	output logic                        is_last,
	output logic [1:0]                  end_reason,
	input  logic                        cfg_we,
	input  logic [utf8e_pkg::CAP_W-1:0] cfg_wdata
);
	import utf8e_pkg::*;

	logic q_full, q_empty, op_push, head_pop;
	op_t  op, head;

	utf8e_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_byte      (in_byte),
		.string_start (string_start),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.q_full       (q_full),
		.op_push      (op_push),
		.op           (op)
	);

	utf8e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op),
		.pop    (head_pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	utf8e_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!q_empty),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.is_last    (is_last),
		.end_reason (end_reason)
	);

endmodule
